>>> rtl/core/imucf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU complementary filter package
// Shared widths, constants, register codes and the word types that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package imucf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int IT_W = 5;
	localparam int CX_W = 36;
	localparam int CZ_W = 30;

	localparam logic signed [CZ_W-1:0] ANG_90 = 30'sd94371840;
	localparam logic signed [CZ_W-1:0] ATAN_Q20 [24] = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
		30'sd3750058, 30'sd1876857, 30'sd938658, 30'sd469357,
		30'sd234682, 30'sd117342, 30'sd58671, 30'sd29335,
		30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
		30'sd917, 30'sd458, 30'sd229, 30'sd115,
		30'sd57, 30'sd29, 30'sd14, 30'sd7
	};

	localparam logic signed [17:0] CORDIC_GAIN = 18'sd107922;
	localparam logic signed [23:0] RATE_K = 24'sd7874672;
	localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
	localparam logic signed [15:0] YAW_HALF = 16'sd23040;

	localparam logic [15:0] WEIGHT_RESET = 16'd64225;
	localparam logic [19:0] MAX_STEP_RESET = 20'd100000;

	typedef enum logic [2:0] {
		REG_BIAS_X   = 3'd0,
		REG_BIAS_Y   = 3'd1,
		REG_BIAS_Z   = 3'd2,
		REG_WEIGHT   = 3'd3,
		REG_MAX_STEP = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] bias_x;
		logic signed [15:0] bias_y;
		logic signed [15:0] bias_z;
		logic [15:0]        weight;
		logic [19:0]        max_step;
	} cfg_t;

	typedef struct packed {
		logic               fused;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [16:0] gx;
		logic signed [16:0] gy;
		logic signed [16:0] gz;
		logic [19:0]        dt;
	} word_t;

endpackage
`default_nettype wire

>>> rtl/core/imucf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU filter front end
// Accepts samples, measures the time step, classifies the sample as fused
// or skipped and removes the gyro offsets.
// ----------------------------------------------------------------------------
module imucf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        time_us,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	input  wire imucf_pkg::cfg_t    cfg,
	input  wire logic               full,
	output logic                    push,
	output imucf_pkg::word_t        push_word
);

	logic [31:0] last_q;
	logic        valid_q;
	logic [31:0] dt;

	assign in_ready = !full;
	assign push     = in_valid && in_ready;
	assign dt       = time_us - last_q;

	always_comb begin
		push_word.fused = valid_q && (dt != 32'd0) && (dt <= {12'd0, cfg.max_step});
		push_word.ax    = accel_x;
		push_word.ay    = accel_y;
		push_word.az    = accel_z;
		push_word.gx    = 17'(gyro_x) - 17'(cfg.bias_x);
		push_word.gy    = 17'(gyro_y) - 17'(cfg.bias_y);
		push_word.gz    = 17'(gyro_z) - 17'(cfg.bias_z);
		push_word.dt    = dt[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 32'd0;
			valid_q <= 1'b0;
		end else if (push) begin
			last_q  <= time_us;
			valid_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/imucf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU filter word queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imucf_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire imucf_pkg::word_t push_word,
	output logic                  full,
	input  wire logic             pop,
	output imucf_pkg::word_t      pop_word,
	output logic                  empty
);

	imucf_pkg::word_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_word = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/core/imucf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU filter back end
// Runs the roll and pitch CORDIC passes, integrates the gyro rates, blends
// and wraps the angles and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module imucf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire imucf_pkg::cfg_t    cfg,
	input  wire logic               empty,
	input  wire imucf_pkg::word_t   pop_word,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      roll_angle,
	output logic signed [16:0]      pitch_angle,
	output logic signed [15:0]      yaw_angle,
	output logic                    fused
);

	localparam int CX_W = imucf_pkg::CX_W;
	localparam int CZ_W = imucf_pkg::CZ_W;
	localparam int IT_W = imucf_pkg::IT_W;
	localparam int M1_W = 38;
	localparam int P_W  = 62;
	localparam int G_W  = 36;
	localparam int V_W  = 55;
	localparam int R_W  = 27;
	localparam int Y_W  = 24;

	localparam logic signed [P_W-1:0] RND27 = 62'sd67108864;
	localparam logic signed [P_W-1:0] RND39 = 62'sd549755813888;
	localparam logic signed [V_W-1:0] RND28 = 55'sd268435456;
	localparam logic signed [Y_W-1:0] Y_HALF = 24'sd23040;
	localparam logic signed [Y_W-1:0] Y_FULL = 24'sd46080;
	localparam logic signed [Y_W-1:0] Y_BIAS = 24'sd552960;
	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_RINIT, S_RITER, S_PMUL, S_PINIT, S_PITER, S_PEND,
		S_GMUL1, S_GMUL2, S_GSUM, S_GADD, S_BMUL, S_BSUM, S_YAW, S_OUT
	} state_t;

	state_t                  state_q;
	imucf_pkg::word_t        item_q;
	logic [IT_W-1:0]         it_q;
	logic [1:0]              axis_q;
	logic signed [CX_W-1:0]  cx_q, cy_q;
	logic signed [CZ_W-1:0]  cz_q;
	logic                    zero_q;
	logic signed [CZ_W-1:0]  roll_a_q, pitch_a_q;
	logic signed [CX_W-1:0]  pmag_q, py_q;
	logic signed [M1_W-1:0]  m1_q;
	logic signed [43:0]      lo_q;
	logic signed [42:0]      hi_q;
	logic signed [P_W-1:0]   p_q;
	logic signed [G_W-1:0]   g_q;
	logic signed [V_W-1:0]   v1_q, v2_q;
	logic signed [16:0]      roll_q, pitch_q;
	logic signed [15:0]      yaw_q;
	logic                    ov_q;
	logic signed [16:0]      ro_q, po_q;
	logic signed [15:0]      yo_q;
	logic                    fo_q;

	logic signed [CX_W-1:0]  ld_x, ld_y, ini_x, ini_y, xs, ys, nx, ny;
	logic signed [CZ_W-1:0]  ini_z, nz, tz;
	logic                    ini_zero;
	logic signed [33:0]      pprod;
	logic signed [16:0]      gsel, ang_sel;
	logic signed [CZ_W-1:0]  a_sel;
	logic signed [20:0]      dts;
	logic signed [16:0]      wa;
	logic signed [17:0]      wb;
	logic signed [V_W-1:0]   vsum;
	logic signed [R_W-1:0]   r;
	logic signed [16:0]      r_sat;
	logic signed [Y_W-1:0]   ydelta, ysum, u;
	logic signed [15:0]      y_new;

	assign pop         = (state_q == S_IDLE) && !empty;
	assign out_valid   = ov_q;
	assign roll_angle  = ro_q;
	assign pitch_angle = po_q;
	assign yaw_angle   = yo_q;
	assign fused       = fo_q;

	always_comb begin
		ld_x = (state_q == S_RINIT) ? (CX_W'(item_q.az) <<< 8) : (pmag_q <<< 8);
		ld_y = (state_q == S_RINIT) ? (CX_W'(item_q.ay) <<< 8) : py_q;
		ini_zero = (ld_x == '0) && (ld_y == '0);
		if (ld_x[CX_W-1]) begin
			if (!ld_y[CX_W-1]) begin
				ini_x = ld_y;
				ini_y = -ld_x;
				ini_z = imucf_pkg::ANG_90;
			end else begin
				ini_x = -ld_y;
				ini_y = ld_x;
				ini_z = -imucf_pkg::ANG_90;
			end
		end else begin
			ini_x = ld_x;
			ini_y = ld_y;
			ini_z = '0;
		end
	end

	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		tz = imucf_pkg::ATAN_Q20[it_q];
		if (!cy_q[CX_W-1]) begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + tz;
		end else begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - tz;
		end
	end

	always_comb begin
		pprod = item_q.ax * imucf_pkg::CORDIC_GAIN;
		dts   = $signed({1'b0, item_q.dt});
		case (axis_q)
			AXIS_ROLL: begin
				gsel    = item_q.gx;
				ang_sel = roll_q;
				a_sel   = roll_a_q;
			end
			AXIS_PITCH: begin
				gsel    = item_q.gy;
				ang_sel = pitch_q;
				a_sel   = pitch_a_q;
			end
			default: begin
				gsel    = item_q.gz;
				ang_sel = pitch_q;
				a_sel   = pitch_a_q;
			end
		endcase
		wa   = $signed({1'b0, cfg.weight});
		wb   = 18'sd65536 - 18'(wa);
		vsum = v1_q + v2_q + RND28;
		r    = R_W'(vsum >>> 29);
		if (r > R_W'(imucf_pkg::ANGLE_LIMIT)) begin
			r_sat = imucf_pkg::ANGLE_LIMIT;
		end else if (r < -R_W'(imucf_pkg::ANGLE_LIMIT)) begin
			r_sat = -imucf_pkg::ANGLE_LIMIT;
		end else begin
			r_sat = r[16:0];
		end
	end

	always_comb begin
		ydelta = Y_W'((p_q + RND39) >>> 40);
		ysum   = Y_W'(yaw_q) + ydelta;
		u      = ysum + Y_HALF + Y_BIAS;
		for (int k = 4; k >= 0; k--) begin
			if (u >= (Y_FULL <<< k)) begin
				u = u - (Y_FULL <<< k);
			end
		end
		if (ysum > Y_HALF || ysum < -Y_HALF) begin
			y_new = 16'(u - Y_HALF);
		end else begin
			y_new = ysum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q    <= '0;
			axis_q  <= AXIS_ROLL;
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
			ov_q    <= 1'b0;
			fo_q    <= 1'b0;
		end else begin
			if (ov_q && out_ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						item_q  <= pop_word;
						state_q <= pop_word.fused ? S_RINIT : S_OUT;
					end
				end
				S_RINIT, S_PINIT: begin
					cx_q    <= ini_x;
					cy_q    <= ini_y;
					cz_q    <= ini_z;
					zero_q  <= ini_zero;
					it_q    <= '0;
					state_q <= (state_q == S_RINIT) ? S_RITER : S_PITER;
				end
				S_RITER, S_PITER: begin
					cx_q <= nx;
					cy_q <= ny;
					cz_q <= nz;
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(imucf_pkg::CORDIC_STEPS - 1)) begin
						state_q <= (state_q == S_RITER) ? S_PMUL : S_PEND;
					end
				end
				S_PMUL: begin
					roll_a_q <= zero_q ? '0 : cz_q;
					pmag_q   <= zero_q ? '0 : cx_q;
					py_q     <= -CX_W'(pprod);
					state_q  <= S_PINIT;
				end
				S_PEND: begin
					pitch_a_q <= zero_q ? '0 : cz_q;
					axis_q    <= AXIS_ROLL;
					state_q   <= S_GMUL1;
				end
				S_GMUL1: begin
					m1_q    <= gsel * dts;
					state_q <= S_GMUL2;
				end
				S_GMUL2: begin
					lo_q    <= $signed({1'b0, m1_q[18:0]}) * imucf_pkg::RATE_K;
					hi_q    <= $signed(m1_q[M1_W-1:19]) * imucf_pkg::RATE_K;
					state_q <= S_GSUM;
				end
				S_GSUM: begin
					p_q     <= (P_W'(hi_q) <<< 19) + P_W'(lo_q);
					state_q <= (axis_q == AXIS_YAW) ? S_YAW : S_GADD;
				end
				S_GADD: begin
					g_q     <= (G_W'(ang_sel) <<< 13) + G_W'((p_q + RND27) >>> 27);
					state_q <= S_BMUL;
				end
				S_BMUL: begin
					v1_q    <= g_q * wa;
					v2_q    <= a_sel * wb;
					state_q <= S_BSUM;
				end
				S_BSUM: begin
					if (axis_q == AXIS_ROLL) begin
						roll_q <= r_sat;
					end else begin
						pitch_q <= r_sat;
					end
					axis_q  <= axis_q + 2'd1;
					state_q <= S_GMUL1;
				end
				S_YAW: begin
					yaw_q   <= y_new;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						ro_q    <= roll_q;
						po_q    <= pitch_q;
						yo_q    <= yaw_q;
						fo_q    <= item_q.fused;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= 17'sd46080 && roll_angle >= -17'sd46080))
		else $error("roll out of range");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040))
		else $error("yaw out of range");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RITER || state_q == S_PITER)
		|-> it_q < IT_W'(imucf_pkg::CORDIC_STEPS))
		else $error("CORDIC step count overrun");

endmodule
`default_nettype wire

>>> rtl/core/imu_complementary_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU complementary filter
// Roll, pitch and yaw in 1/128 degree from timestamped IMU samples.
// ----------------------------------------------------------------------------
// A fused sample runs through the back end as two CORDIC passes of
// CORDIC_STEPS iterations each (roll, then pitch from the roll magnitude)
// and multiply steps for each axis on one shared sequencer. A skipped
// sample (first sample, zero step or step above max_step) goes from idle straight to the output state.
// A two-word queue lets the front end take samples while the back end works,
// and an output register holds the result until it is taken. Registers are
// written through the cfg channel, index 0..4, always ready.
module imu_complementary_filter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        time_us,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      roll_angle,
	output logic signed [16:0]      pitch_angle,
	output logic signed [15:0]      yaw_angle,
	output logic                    fused,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [19:0]        cfg_data
);

	imucf_pkg::cfg_t  cfg_q;
	imucf_pkg::word_t push_word, pop_word;
	logic             push, pop, full, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_x   <= '0;
			cfg_q.bias_y   <= '0;
			cfg_q.bias_z   <= '0;
			cfg_q.weight   <= imucf_pkg::WEIGHT_RESET;
			cfg_q.max_step <= imucf_pkg::MAX_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (imucf_pkg::cfg_reg_t'(cfg_index))
				imucf_pkg::REG_BIAS_X:   cfg_q.bias_x   <= $signed(cfg_data[15:0]);
				imucf_pkg::REG_BIAS_Y:   cfg_q.bias_y   <= $signed(cfg_data[15:0]);
				imucf_pkg::REG_BIAS_Z:   cfg_q.bias_z   <= $signed(cfg_data[15:0]);
				imucf_pkg::REG_WEIGHT:   cfg_q.weight   <= cfg_data[15:0];
				imucf_pkg::REG_MAX_STEP: cfg_q.max_step <= cfg_data;
				default: ;
			endcase
		end
	end

	imucf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_us   (time_us),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.gyro_x    (gyro_x),
		.gyro_y    (gyro_y),
		.gyro_z    (gyro_z),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_word (push_word)
	);

	imucf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	imucf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.empty       (empty),
		.pop_word    (pop_word),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.fused       (fused)
	);

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU complementary filter testbench
// Drives timestamped IMU samples and register writes into the filter, predicts
// roll, pitch, yaw and the fused flag with a bit-accurate CORDIC model, and
// compares every result word against the predicted queue under random stalls.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic signed [16:0] roll;
		logic signed [16:0] pitch;
		logic signed [15:0] yaw;
		logic               fused;
	} angles_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] time_us;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic signed [15:0] gyro_x, gyro_y, gyro_z;
	logic out_valid;
	logic out_ready;
	logic signed [16:0] roll_angle, pitch_angle;
	logic signed [15:0] yaw_angle;
	logic fused;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;

	int send_idle_pct;
	int take_idle_pct;
	int error_count;
	int unsigned cycle_count;
	angles_t angles_due[$];

	logic [31:0] m_last_time;
	logic        m_time_valid;
	longint      m_roll, m_pitch, m_yaw;
	longint      m_bias_x, m_bias_y, m_bias_z;
	longint      m_weight, m_max_step;
	logic [31:0] clock_now;

	imu_complementary_filter i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.time_us(time_us),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .fused(fused),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint shift_down(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint vector_angle(longint x, longint y, output longint mag);
		longint z, t, xs, ys;
		z = 0;
		mag = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = imucf_pkg::ANG_90;
			end else begin
				t = x; x = -y; y = t; z = -imucf_pkg::ANG_90;
			end
		end
		for (int i = 0; i < imucf_pkg::CORDIC_STEPS && i < 24; i++) begin
			xs = shift_down(x, i);
			ys = shift_down(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(imucf_pkg::ATAN_Q20[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(imucf_pkg::ATAN_Q20[i]);
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic longint blend_angle(longint ang, longint prod, longint accel_ang);
		longint g, v, r;
		g = ang * 8192 + shift_down(prod + (64'sd1 <<< 26), 27);
		v = m_weight * g + (65536 - m_weight) * accel_ang;
		r = shift_down(v + (64'sd1 <<< 28), 29);
		if (r > 46080) r = 46080;
		if (r < -46080) r = -46080;
		return r;
	endfunction

	function automatic angles_t predict_angles(logic [31:0] t, longint ax, longint ay,
		longint az, longint gx, longint gy, longint gz);
		angles_t a;
		logic [31:0] dt;
		longint mag, spare, roll_a, pitch_a, y;
		a.fused = 1'b0;
		if (!m_time_valid) begin
			m_time_valid = 1'b1;
			m_last_time = t;
		end else begin
			dt = t - m_last_time;
			m_last_time = t;
			if (dt != 0 && longint'(dt) <= m_max_step) begin
				gx -= m_bias_x; gy -= m_bias_y; gz -= m_bias_z;
				roll_a = vector_angle(az * 256, ay * 256, mag);
				pitch_a = vector_angle(mag * 256, -ax * 107922, spare);
				m_roll = blend_angle(m_roll, gx * longint'(dt) * 7874672, roll_a);
				m_pitch = blend_angle(m_pitch, gy * longint'(dt) * 7874672, pitch_a);
				y = m_yaw + shift_down(gz * longint'(dt) * 7874672 + (64'sd1 <<< 39), 40);
				if (y > 23040 || y < -23040) begin
					y = (y + 23040) % 46080;
					if (y < 0) y += 46080;
					y -= 23040;
				end
				m_yaw = y;
				a.fused = 1'b1;
			end
		end
		a.roll = m_roll[16:0];
		a.pitch = m_pitch[16:0];
		a.yaw = m_yaw[15:0];
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	always @(posedge clk) begin
		angles_t e;
		if (arst_n && out_valid && out_ready) begin
			if (angles_due.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				e = angles_due.pop_front();
				if (roll_angle !== e.roll) report_mismatch("roll", roll_angle, e.roll);
				if (pitch_angle !== e.pitch) report_mismatch("pitch", pitch_angle, e.pitch);
				if (yaw_angle !== e.yaw) report_mismatch("yaw", yaw_angle, e.yaw);
				if (fused !== e.fused) report_mismatch("fused", fused, e.fused);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= take_idle_pct);
	end

	task automatic send_sample(logic [31:0] t, logic [15:0] ax, logic [15:0] ay,
		logic [15:0] az, logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		time_us <= t;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
		angles_due.push_back(predict_angles(t, longint'($signed(ax)), longint'($signed(ay)),
			longint'($signed(az)), longint'($signed(gx)), longint'($signed(gy)),
			longint'($signed(gz))));
		clock_now = t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(imucf_pkg::cfg_reg_t idx, logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			imucf_pkg::REG_BIAS_X:   m_bias_x = longint'($signed(value[15:0]));
			imucf_pkg::REG_BIAS_Y:   m_bias_y = longint'($signed(value[15:0]));
			imucf_pkg::REG_BIAS_Z:   m_bias_z = longint'($signed(value[15:0]));
			imucf_pkg::REG_WEIGHT:   m_weight = value[15:0];
			imucf_pkg::REG_MAX_STEP: m_max_step = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_random(int step_max);
		logic [31:0] dt;
		case ($urandom_range(9))
			0: dt = $urandom();
			1: dt = 0;
			2: dt = m_max_step[31:0] + $urandom_range(2);
			default: dt = $urandom_range(step_max, 1);
		endcase
		send_sample(clock_now + dt, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic test_directed;
		send_sample(32'd1000, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0);
		send_sample(32'd1000, 16'sd0, 16'sd0, 16'sd256, 16'sd100, 16'sd0, 16'sd0);
		send_sample(32'd2000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_sample(32'd3000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(32'd4000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(32'd5000, 16'sd0, 16'sd100, -16'sd200, 16'sd0, 16'sd0, 16'sd0);
		send_sample(32'd6000, 16'sd0, -16'sd100, -16'sd200, 16'sd0, 16'sd0, 16'sd0);
		send_sample(32'd6000 + 100000, 16'sd10, 16'sd5, 16'sd256, 16'sh7fff, -16'sd5, 16'sh7fff);
		send_sample(32'd6000 + 200001, 16'sd10, 16'sd5, 16'sd256, 16'sd1, 16'sd1, 16'sd1);
		send_sample(32'hffff_fff0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0);
		send_sample(32'h0000_0010, -16'sd256, 16'sd0, 16'sd0, 16'sd50, 16'sd50, 16'sd50);
		for (int i = 0; i < 8; i++)
			send_sample(clock_now + 100000, 16'sd0, 16'sd0, 16'sd256,
				16'sh7fff, 16'sh8000, 16'sh7fff);
		drain();
	endtask

	task automatic test_registers;
		write_reg(imucf_pkg::REG_BIAS_X, 20'h08000);
		write_reg(imucf_pkg::REG_BIAS_Y, 20'h07fff);
		write_reg(imucf_pkg::REG_BIAS_Z, 20'h0ffff);
		write_reg(imucf_pkg::REG_WEIGHT, 20'd0);
		write_reg(imucf_pkg::REG_MAX_STEP, 20'd1000000);
		for (int i = 0; i < 20; i++) send_random(1000000);
		drain();
		write_reg(imucf_pkg::REG_WEIGHT, 20'hffff);
		write_reg(imucf_pkg::REG_MAX_STEP, 20'd1);
		for (int i = 0; i < 20; i++) send_random(2);
		drain();
		write_reg(imucf_pkg::REG_MAX_STEP, 20'd0);
		for (int i = 0; i < 5; i++) send_random(5);
		drain();
		write_reg(imucf_pkg::REG_MAX_STEP, 20'hfffff);
		for (int i = 0; i < 20; i++) send_random(1048575);
		drain();
	endtask

	task automatic test_random_phase(int sender_pct, int taker_pct, int count);
		send_idle_pct = sender_pct;
		take_idle_pct = taker_pct;
		write_reg(imucf_pkg::REG_BIAS_X, 20'($urandom_range(65535)));
		write_reg(imucf_pkg::REG_BIAS_Y, 20'($urandom_range(255)));
		write_reg(imucf_pkg::REG_BIAS_Z, 20'($urandom_range(65535)));
		write_reg(imucf_pkg::REG_WEIGHT, 20'($urandom_range(65535, 60000)));
		write_reg(imucf_pkg::REG_MAX_STEP, 20'd100000);
		for (int i = 0; i < count; i++) send_random(5000);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = imucf_pkg::REG_BIAS_X;
		cfg_data = '0;
		time_us = '0;
		accel_x = '0; accel_y = '0; accel_z = '0;
		gyro_x = '0; gyro_y = '0; gyro_z = '0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 26;
		take_idle_pct = 50;
		m_last_time = '0;
		m_time_valid = 1'b0;
		m_roll = 0; m_pitch = 0; m_yaw = 0;
		m_bias_x = 0; m_bias_y = 0; m_bias_z = 0;
		m_weight = imucf_pkg::WEIGHT_RESET;
		m_max_step = imucf_pkg::MAX_STEP_RESET;
		clock_now = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random_phase(26, 50, 650);
		test_random_phase(50, 26, 650);
		test_random_phase(0, 0, 650);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/imucf_pkg.sv
rtl/core/imucf_front.sv
rtl/core/imucf_fifo.sv
rtl/core/imucf_back.sv
rtl/core/imu_complementary_filter.sv
bench/testbench.sv
